@@ rtl/pn2d_pkg.sv @@
// Package for the 2D gradient noise core: item codes, queue item type and
// fixed-point constants. Depends on nothing; every file but pn2d_if imports it.
package pn2d_pkg;

  // Input kind codes as they arrive on the input channel.
  localparam logic [1:0] KIND_LOAD_PERM = 2'd0;
  localparam logic [1:0] KIND_LOAD_GRAD = 2'd1;
  localparam logic [1:0] KIND_EVAL      = 2'd2;

  // Operation carried from the front end to the back end.
  typedef enum logic [1:0] {
    OP_PERM = 2'd0,
    OP_GRAD = 2'd1,
    OP_EVAL = 2'd2
  } pn2d_op_t;

  // One queued transaction.
  typedef struct packed {
    pn2d_op_t           op;
    logic [7:0]         index;
    logic [7:0]         perm_entry;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
  } pn2d_item_t;

  // Queue depth between the front end and the back end.
  localparam int QUEUE_DEPTH = 4;
  // Width of a dot product and of a blended value.
  localparam int DOT_W = 18;
  // Output format and saturation limit.
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_LIMIT = 16384;

endpackage

@@ rtl/pn2d_if.sv @@
// Channel interfaces for the 2D gradient noise core: input and result.
// Depends on nothing; used by the front end, back end and top level.
interface pn2d_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         index;
  logic [7:0]         perm_entry;
  logic signed [15:0] grad_x;
  logic signed [15:0] grad_y;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;

  modport source (output valid, kind, index, perm_entry, grad_x, grad_y, coord_x, coord_y,
                  input ready);
  modport sink (input valid, kind, index, perm_entry, grad_x, grad_y, coord_x, coord_y,
                output ready);
endinterface

interface pn2d_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] noise;

  modport source (output valid, noise, input ready);
  modport sink (input valid, noise, output ready);
endinterface

@@ rtl/pn2d_front.sv @@
// Front end: accepts input transactions, classifies them and queues them.
// Depends on pn2d_pkg and pn2d_in_if.
module pn2d_front (
  input  logic                clk,
  input  logic                rst_n,
  pn2d_in_if.sink             in_if,
  output logic                q_valid,
  output pn2d_pkg::pn2d_item_t q_item,
  input  logic                q_pop
);
  import pn2d_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  pn2d_item_t       queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             push;
  logic             keep;
  pn2d_item_t       item;

  // Classify the incoming transaction; the unused kind is dropped.
  always_comb begin
    keep         = 1'b1;
    item.op      = OP_EVAL;
    item.index      = in_if.index;
    item.perm_entry = in_if.perm_entry;
    item.grad_x     = in_if.grad_x;
    item.grad_y     = in_if.grad_y;
    item.coord_x    = in_if.coord_x;
    item.coord_y    = in_if.coord_y;
    unique case (in_if.kind)
      KIND_LOAD_PERM: item.op = OP_PERM;
      KIND_LOAD_GRAD: item.op = OP_GRAD;
      KIND_EVAL:      item.op = OP_EVAL;
      default:        keep = 1'b0;
    endcase
  end

  assign in_if.ready = (count_r != (PTR_W+1)'(QUEUE_DEPTH));
  assign push        = in_if.valid && in_if.ready && keep;
  assign q_valid     = (count_r != '0);
  assign q_item      = queue_r[rptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wptr_nxt  = push  ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = q_pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r + (PTR_W+1)'(push) - (PTR_W+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wptr_r] <= item;
    end
  end

endmodule

@@ rtl/pn2d_back.sv @@
// Back end: table banks and the evaluation pipeline for the noise core.
// Depends on pn2d_pkg and pn2d_out_if.
module pn2d_back #(
  parameter int TABLE_SIZE      = 256,
  parameter int COORD_FRAC_BITS = 16,
  parameter int GRAD_FRAC_BITS  = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  pn2d_pkg::pn2d_item_t q_item,
  output logic                 q_pop,
  pn2d_out_if.source           out_if
);
  import pn2d_pkg::*;

  localparam int TB  = $clog2(TABLE_SIZE);
  localparam int F   = COORD_FRAC_BITS;
  localparam int RW  = F + 1;
  localparam int PW  = RW + 16;
  localparam int SW  = PW + 1;
  localparam int KW  = F + 2;
  localparam int BPW = DOT_W + F + 2;
  localparam int NW  = DOT_W + OUT_FRAC_BITS;
  localparam logic signed [NW-1:0] LIM_POS = NW'(OUT_LIMIT);
  localparam logic signed [NW-1:0] LIM_NEG = -NW'(OUT_LIMIT);

  logic adv;
  logic out_valid_r;
  logic signed [15:0] out_noise_r;

  // The whole pipeline moves when the output register is free or drained.
  assign adv            = !out_valid_r || out_if.ready;
  assign q_pop          = adv && q_valid;
  assign out_if.valid   = out_valid_r;
  assign out_if.noise   = out_noise_r;

  // Stage 0: cell and fraction split, load address and value.
  logic signed [TB+31:0] cx_ext, cy_ext;
  logic [TB+7:0]         idx_ext, val_ext;
  logic [TB-1:0]         bx0, bx1, by0, ld_addr, ld_perm;

  always_comb begin
    cx_ext  = {{TB{q_item.coord_x[31]}}, q_item.coord_x};
    cy_ext  = {{TB{q_item.coord_y[31]}}, q_item.coord_y};
    bx0     = cx_ext[F +: TB];
    by0     = cy_ext[F +: TB];
    bx1     = bx0 + TB'(1);
    idx_ext = {{TB{1'b0}}, q_item.index};
    val_ext = {{TB{1'b0}}, q_item.perm_entry};
    ld_addr = idx_ext[TB-1:0];
    ld_perm = val_ext[TB-1:0];
  end

  // Permutation bank A serves the first hash level.
  logic [TB-1:0] perm_a_mem [TABLE_SIZE];
  logic [TB-1:0] pi_r, pj_r;

  always_ff @(posedge clk) begin
    if (q_pop && q_item.op == OP_PERM) begin
      perm_a_mem[ld_addr] <= ld_perm;
    end
    if (adv) begin
      pi_r <= perm_a_mem[bx0];
      pj_r <= perm_a_mem[bx1];
    end
  end

  // Stage 1 registers.
  logic               s1_v_r;
  pn2d_op_t           s1_op_r;
  logic [TB-1:0]      s1_addr_r, s1_perm_r, s1_by0_r;
  logic signed [15:0] s1_gx_r, s1_gy_r;
  logic [F-1:0]       s1_fx_r, s1_fy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r   <= q_item.op;
      s1_addr_r <= ld_addr;
      s1_perm_r <= ld_perm;
      s1_by0_r  <= by0;
      s1_gx_r   <= q_item.grad_x;
      s1_gy_r   <= q_item.grad_y;
      s1_fx_r   <= q_item.coord_x[F-1:0];
      s1_fy_r   <= q_item.coord_y[F-1:0];
    end
  end

  // Stage 1: second hash level addresses.
  logic [TB-1:0] by1, a00, a10, a01, a11;
  logic          s1_perm_wr;

  always_comb begin
    by1 = s1_by0_r + TB'(1);
    a00 = pi_r + s1_by0_r;
    a10 = pj_r + s1_by0_r;
    a01 = pi_r + by1;
    a11 = pj_r + by1;
    s1_perm_wr = adv && s1_v_r && (s1_op_r == OP_PERM);
  end

  // Permutation banks B and C serve the second hash level.
  logic [TB-1:0] perm_b_mem [TABLE_SIZE];
  logic [TB-1:0] perm_c_mem [TABLE_SIZE];
  logic [TB-1:0] h00_r, h10_r, h01_r, h11_r;

  always_ff @(posedge clk) begin
    if (s1_perm_wr) begin
      perm_b_mem[s1_addr_r] <= s1_perm_r;
    end
    if (adv) begin
      h00_r <= perm_b_mem[a00];
      h10_r <= perm_b_mem[a10];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_perm_wr) begin
      perm_c_mem[s1_addr_r] <= s1_perm_r;
    end
    if (adv) begin
      h01_r <= perm_c_mem[a01];
      h11_r <= perm_c_mem[a11];
    end
  end

  // Stage 2 registers, including the first fade product.
  logic               s2_v_r;
  pn2d_op_t           s2_op_r;
  logic [TB-1:0]      s2_addr_r;
  logic signed [15:0] s2_gx_r, s2_gy_r;
  logic [F-1:0]       s2_fx_r, s2_fy_r;
  logic [2*F-1:0]     s2_tx2_r, s2_ty2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op_r   <= s1_op_r;
      s2_addr_r <= s1_addr_r;
      s2_gx_r   <= s1_gx_r;
      s2_gy_r   <= s1_gy_r;
      s2_fx_r   <= s1_fx_r;
      s2_fy_r   <= s1_fy_r;
      s2_tx2_r  <= s1_fx_r * s1_fx_r;
      s2_ty2_r  <= s1_fy_r * s1_fy_r;
    end
  end

  // Stage 2: gradient lookup and second fade product.
  logic          s2_grad_wr;
  logic [31:0]   s2_grad;
  logic [KW-1:0] kx, ky;

  always_comb begin
    s2_grad_wr = adv && s2_v_r && (s2_op_r == OP_GRAD);
    s2_grad    = {s2_gx_r, s2_gy_r};
    kx = (KW'(3) << F) - {1'b0, s2_fx_r, 1'b0};
    ky = (KW'(3) << F) - {1'b0, s2_fy_r, 1'b0};
  end

  logic [31:0] grad_0_mem [TABLE_SIZE];
  logic [31:0] grad_1_mem [TABLE_SIZE];
  logic [31:0] g00_r, g10_r, g01_r, g11_r;

  always_ff @(posedge clk) begin
    if (s2_grad_wr) begin
      grad_0_mem[s2_addr_r] <= s2_grad;
    end
    if (adv) begin
      g00_r <= grad_0_mem[h00_r];
      g10_r <= grad_0_mem[h10_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_grad_wr) begin
      grad_1_mem[s2_addr_r] <= s2_grad;
    end
    if (adv) begin
      g01_r <= grad_1_mem[h01_r];
      g11_r <= grad_1_mem[h11_r];
    end
  end

  // Stage 3 registers.
  logic              s3_v_r;
  logic [F-1:0]      s3_fx_r, s3_fy_r;
  logic [2*F+1:0]    s3_sxp_r, s3_syp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r && (s2_op_r == OP_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_fx_r  <= s2_fx_r;
      s3_fy_r  <= s2_fy_r;
      s3_sxp_r <= s2_tx2_r[2*F-1:F] * kx;
      s3_syp_r <= s2_ty2_r[2*F-1:F] * ky;
    end
  end

  // Stage 3: corner offsets times gradient components.
  logic signed [RW-1:0] rx0, rx1, ry0, ry1;

  always_comb begin
    rx0 = $signed({1'b0, s3_fx_r});
    ry0 = $signed({1'b0, s3_fy_r});
    rx1 = rx0 - (RW'(1) << F);
    ry1 = ry0 - (RW'(1) << F);
  end

  logic              s4_v_r;
  logic signed [PW-1:0] m00x_r, m00y_r, m10x_r, m10y_r;
  logic signed [PW-1:0] m01x_r, m01y_r, m11x_r, m11y_r;
  logic [F-1:0]      s4_sx_r, s4_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m00x_r  <= rx0 * $signed(g00_r[31:16]);
      m00y_r  <= ry0 * $signed(g00_r[15:0]);
      m10x_r  <= rx1 * $signed(g10_r[31:16]);
      m10y_r  <= ry0 * $signed(g10_r[15:0]);
      m01x_r  <= rx0 * $signed(g01_r[31:16]);
      m01y_r  <= ry1 * $signed(g01_r[15:0]);
      m11x_r  <= rx1 * $signed(g11_r[31:16]);
      m11y_r  <= ry1 * $signed(g11_r[15:0]);
      s4_sx_r <= s3_sxp_r[2*F-1:F];
      s4_sy_r <= s3_syp_r[2*F-1:F];
    end
  end

  // Stage 4: dot product sums, floored to the gradient fraction.
  logic signed [SW-1:0] d00, d10, d01, d11;

  always_comb begin
    d00 = SW'(m00x_r) + SW'(m00y_r);
    d10 = SW'(m10x_r) + SW'(m10y_r);
    d01 = SW'(m01x_r) + SW'(m01y_r);
    d11 = SW'(m11x_r) + SW'(m11y_r);
  end

  logic                    s5_v_r;
  logic signed [DOT_W-1:0] u00_r, u10_r, u01_r, u11_r;
  logic [F-1:0]            s5_sx_r, s5_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u00_r   <= d00[F +: DOT_W];
      u10_r   <= d10[F +: DOT_W];
      u01_r   <= d01[F +: DOT_W];
      u11_r   <= d11[F +: DOT_W];
      s5_sx_r <= s4_sx_r;
      s5_sy_r <= s4_sy_r;
    end
  end

  // Stage 5: horizontal blend products.
  logic signed [DOT_W:0] diff0, diff1;

  always_comb begin
    diff0 = (DOT_W+1)'(u10_r) - (DOT_W+1)'(u00_r);
    diff1 = (DOT_W+1)'(u11_r) - (DOT_W+1)'(u01_r);
  end

  logic                    s6_v_r;
  logic signed [BPW-1:0]   bp0_r, bp1_r;
  logic signed [DOT_W-1:0] s6_u00_r, s6_u01_r;
  logic [F-1:0]            s6_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (adv) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bp0_r    <= diff0 * $signed({1'b0, s5_sx_r});
      bp1_r    <= diff1 * $signed({1'b0, s5_sx_r});
      s6_u00_r <= u00_r;
      s6_u01_r <= u01_r;
      s6_sy_r  <= s5_sy_r;
    end
  end

  // Stage 6: horizontal blend sums.
  logic signed [DOT_W:0] row_a, row_b;

  always_comb begin
    row_a = (DOT_W+1)'(s6_u00_r) + bp0_r[F +: DOT_W+1];
    row_b = (DOT_W+1)'(s6_u01_r) + bp1_r[F +: DOT_W+1];
  end

  logic                    s7_v_r;
  logic signed [DOT_W-1:0] s7_a_r, s7_b_r;
  logic [F-1:0]            s7_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (adv) begin
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_a_r  <= row_a[DOT_W-1:0];
      s7_b_r  <= row_b[DOT_W-1:0];
      s7_sy_r <= s6_sy_r;
    end
  end

  // Stage 7: vertical blend product.
  logic signed [DOT_W:0] diff_v;

  assign diff_v = (DOT_W+1)'(s7_b_r) - (DOT_W+1)'(s7_a_r);

  logic                    s8_v_r;
  logic signed [BPW-1:0]   vp_r;
  logic signed [DOT_W-1:0] s8_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else if (adv) begin
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vp_r   <= diff_v * $signed({1'b0, s7_sy_r});
      s8_a_r <= s7_a_r;
    end
  end

  // Stage 8: vertical blend sum, output scaling and saturation.
  logic signed [DOT_W:0]   nsum;
  logic signed [NW-1:0]    nwide, nscaled, nsat;

  always_comb begin
    nsum    = (DOT_W+1)'(s8_a_r) + vp_r[F +: DOT_W+1];
    nwide   = $signed({nsum[DOT_W-1:0], {OUT_FRAC_BITS{1'b0}}});
    nscaled = nwide >>> GRAD_FRAC_BITS;
    if (nscaled > LIM_POS) begin
      nsat = LIM_POS;
    end else if (nscaled < LIM_NEG) begin
      nsat = LIM_NEG;
    end else begin
      nsat = nscaled;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_noise_r <= nsat[15:0];
    end
  end

endmodule

@@ rtl/perlin_noise_2d_core.sv @@
// Top level of the 2D gradient noise core: front end, queue and back end.
// Depends on pn2d_pkg, pn2d_if, pn2d_front and pn2d_back.
//
// Usage: the input channel carries three kinds of transaction. Kind 0 writes
// one permutation entry, kind 1 writes one gradient entry (x high, y low),
// kind 2 evaluates the noise at a signed fixed-point point; kind 3 is
// dropped. Only evaluations give a transaction on the result channel, in
// input order. Tables must be loaded before the entries are used.
// Throughput: one transaction per cycle while the receiver does not stall,
// set by the replicated table banks that let the lookups of each hash and
// gradient level of one point happen in parallel. An evaluation passes the
// queue storage, the pipeline stage registers in order and the output register.
// Reset clears the queue, the pipeline valid bits and the output valid bit;
// the tables keep their contents and are undefined until written.
// When the receiver stalls, the result holds in the output register and
// the pipeline freezes; the four-entry queue keeps taking input until full.
module perlin_noise_2d_core #(
  parameter int TABLE_SIZE      = 256,
  parameter int COORD_FRAC_BITS = 16,
  parameter int GRAD_FRAC_BITS  = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  pn2d_in_if.sink     in_if,
  pn2d_out_if.source  out_if
);
  import pn2d_pkg::*;

  logic       q_valid;
  logic       q_pop;
  pn2d_item_t q_item;

  // Front end: accept and queue transactions.
  pn2d_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // Back end: tables and evaluation pipeline.
  pn2d_back #(
    .TABLE_SIZE      (TABLE_SIZE),
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .GRAD_FRAC_BITS  (GRAD_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

@@ tb/sv/perlin_noise_2d_core_test.sv @@
// Self-checking test of the 2D gradient noise core: loads both tables, then runs
// directed evaluations and a random mix of loads, evaluations and dropped items against a local predictor.
// Depends on pn2d_pkg, pn2d_if and perlin_noise_2d_core.
`timescale 1ns / 100ps

module perlin_noise_2d_core_test;
  import pn2d_pkg::*;

  localparam int CELLS      = 256;
  localparam int FRAC       = 16;
  localparam int CYCLE_CAP  = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pn2d_in_if  in_if ();
  pn2d_out_if out_if ();

  perlin_noise_2d_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always #10 clk = ~clk;

  // Shadow tables and pending work.
  logic [7:0]         perm_shadow [CELLS];
  logic signed [15:0] gx_shadow [CELLS];
  logic signed [15:0] gy_shadow [CELLS];
  pn2d_item_t         pending_items [$];
  logic signed [15:0] expected_noise [$];
  int                 error_count = 0;
  int                 cycle_count = 0;
  bit                 stimulus_done = 1'b0;

  function automatic longint floor_div(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint fade_curve(longint t);
    longint t2;
    t2 = (t * t) >>> FRAC;
    return (t2 * ((longint'(3) << FRAC) - 2 * t)) >>> FRAC;
  endfunction

  function automatic longint grad_dot(int h, longint rx, longint ry);
    return floor_div(rx * longint'(gx_shadow[h]) + ry * longint'(gy_shadow[h]), FRAC);
  endfunction

  function automatic longint mix(longint a, longint b, longint s);
    return a + floor_div((b - a) * s, FRAC);
  endfunction

  // Predicted noise for one evaluation, from the shadow tables.
  function automatic logic signed [15:0] noise_at(logic signed [31:0] cx,
                                                  logic signed [31:0] cy);
    int bx0, by0, bx1, by1, pi, pj;
    longint rx0, ry0, rx1, ry1, sx, sy, a, b, n;
    bx0 = (cx >>> FRAC) & (CELLS - 1);
    by0 = (cy >>> FRAC) & (CELLS - 1);
    rx0 = longint'(cx[15:0]);
    ry0 = longint'(cy[15:0]);
    bx1 = (bx0 + 1) % CELLS;
    by1 = (by0 + 1) % CELLS;
    rx1 = rx0 - (longint'(1) << FRAC);
    ry1 = ry0 - (longint'(1) << FRAC);
    pi = perm_shadow[bx0];
    pj = perm_shadow[bx1];
    sx = fade_curve(rx0);
    sy = fade_curve(ry0);
    a = mix(grad_dot(perm_shadow[(pi + by0) % CELLS], rx0, ry0),
            grad_dot(perm_shadow[(pj + by0) % CELLS], rx1, ry0), sx);
    b = mix(grad_dot(perm_shadow[(pi + by1) % CELLS], rx0, ry1),
            grad_dot(perm_shadow[(pj + by1) % CELLS], rx1, ry1), sx);
    n = mix(a, b, sy);
    if (n > OUT_LIMIT) n = OUT_LIMIT;
    if (n < -OUT_LIMIT) n = -OUT_LIMIT;
    return 16'(n);
  endfunction

  // Apply one accepted transaction to the shadow state.
  task automatic track_item(pn2d_item_t it);
    case (it.op)
      OP_PERM: perm_shadow[it.index] = it.perm_entry;
      OP_GRAD: begin
        gx_shadow[it.index] = it.grad_x;
        gy_shadow[it.index] = it.grad_y;
      end
      OP_EVAL: expected_noise.push_back(noise_at(it.coord_x, it.coord_y));
      default: ;
    endcase
  endtask

  function automatic pn2d_item_t make_item(logic [1:0] kind);
    pn2d_item_t it;
    it.op = pn2d_op_t'(kind);
    it.index = 8'($urandom);
    it.perm_entry = 8'($urandom);
    it.grad_x = 16'($urandom);
    it.grad_y = 16'($urandom);
    it.coord_x = $urandom;
    it.coord_y = $urandom;
    return it;
  endfunction

  function automatic logic signed [15:0] rand_grad();
    case ($urandom_range(0, 5))
      0: return -16'sd16384;
      1: return 16'sd16384;
      2: return -16'sd32768;
      3: return 16'sh7fff;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic add_eval(logic signed [31:0] x, logic signed [31:0] y);
    pn2d_item_t it;
    it = make_item(KIND_EVAL);
    it.coord_x = x;
    it.coord_y = y;
    pending_items.push_back(it);
  endtask

  // Stimulus: full table load, directed corners, one item of the unused kind, then a random mix.
  initial begin
    pn2d_item_t it;
    for (int i = 0; i < CELLS; i++) begin
      it = make_item(KIND_LOAD_PERM);
      it.index = 8'(i);
      it.perm_entry = 8'($urandom);
      pending_items.push_back(it);
      it = make_item(KIND_LOAD_GRAD);
      it.index = 8'(i);
      it.grad_x = rand_grad();
      it.grad_y = rand_grad();
      pending_items.push_back(it);
    end
    add_eval(32'sh0, 32'sh0);
    add_eval(32'sh7fffffff, 32'sh7fffffff);
    add_eval(32'sh80000000, 32'sh80000000);
    add_eval(32'shffffffff, 32'sh00008000);
    add_eval(-32'sd4096 * 65536 - 1, 32'sh00ffffff);
    add_eval(32'sh0000ffff, -32'sd65536);
    add_eval(32'sh00ff8000, 32'sh01007fff);
    add_eval(32'shffff0001, 32'sh55555555);
    // Unused kind is dropped by the block.
    it = make_item(2'd3);
    pending_items.push_back(it);
    for (int n = 0; n < 430; n++) begin
      case ($urandom_range(0, 19))
        0: it = make_item(KIND_LOAD_PERM);
        1: begin
          it = make_item(KIND_LOAD_GRAD);
          it.grad_x = rand_grad();
          it.grad_y = rand_grad();
        end
        2: it = make_item(2'd3);
        3: begin
          it = make_item(KIND_EVAL);
          it.coord_x = $signed($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
        end
        default: it = make_item(KIND_EVAL);
      endcase
      pending_items.push_back(it);
    end
    stimulus_done = 1'b1;
  end

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.kind = '0;
    in_if.index = '0;
    in_if.perm_entry = '0;
    in_if.grad_x = '0;
    in_if.grad_y = '0;
    in_if.coord_x = '0;
    in_if.coord_y = '0;
    out_if.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  task automatic it_drive(pn2d_item_t it);
    in_if.valid <= 1'b1;
    in_if.kind <= 2'(it.op);
    in_if.index <= it.index;
    in_if.perm_entry <= it.perm_entry;
    in_if.grad_x <= it.grad_x;
    in_if.grad_y <= it.grad_y;
    in_if.coord_x <= it.coord_x;
    in_if.coord_y <= it.coord_y;
  endtask

  bit accepted_in;
  always @(posedge clk) accepted_in <= rst_n && in_if.valid && in_if.ready;

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_if.valid || accepted_in) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_if.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it_drive(pending_items.pop_front());
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls in a pattern of its own, with long stall-free stretches.
  always @(negedge clk) begin
    if (rst_n) begin
      if ((cycle_count / 300) % 3 == 0) out_if.ready <= 1'b1;
      else out_if.ready <= ($urandom_range(0, 9) < 6);
    end
  end

  // Monitor: track accepted inputs and check each result transaction.
  always @(posedge clk) begin
    pn2d_item_t seen;
    cycle_count <= cycle_count + 1;
    if (rst_n && in_if.valid && in_if.ready && in_if.kind != 2'd3) begin
      seen.op = pn2d_op_t'(in_if.kind);
      seen.index = in_if.index;
      seen.perm_entry = in_if.perm_entry;
      seen.grad_x = in_if.grad_x;
      seen.grad_y = in_if.grad_y;
      seen.coord_x = in_if.coord_x;
      seen.coord_y = in_if.coord_y;
      track_item(seen);
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_noise.size() == 0) begin
        $display("%0t: unexpected noise transaction, actual %0d", $time, out_if.noise);
        error_count <= error_count + 1;
      end else if (out_if.noise !== expected_noise[0]) begin
        $display("%0t: noise mismatch, expected %0d, actual %0d", $time,
                 expected_noise[0], out_if.noise);
        error_count <= error_count + 1;
        void'(expected_noise.pop_front());
      end else begin
        void'(expected_noise.pop_front());
      end
    end
  end

  // End of run: drain, settle, report.
  initial begin
    wait (stimulus_done && rst_n);
    wait (pending_items.size() == 0 && !in_if.valid);
    wait (expected_noise.size() == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_noise.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycle_count >= CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

@@ files.f @@
rtl/pn2d_pkg.sv
rtl/pn2d_if.sv
rtl/pn2d_front.sv
rtl/pn2d_back.sv
rtl/perlin_noise_2d_core.sv
tb/sv/perlin_noise_2d_core_test.sv
